// File: hdl/rdp_pkg.sv
// Shared constants and types for the radial depth to point pipeline.
package rdp_pkg;

   // Default widths of the pixel coordinate and the raw depth sample
   localparam int COORD_BITS_DEFAULT = 12;
   localparam int DEPTH_BITS_DEFAULT = 16;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENABLE        = 3'd0,
      CSR_RADIAL_MODE   = 3'd1,
      CSR_FOCAL_X       = 3'd2,
      CSR_CENTER_X      = 3'd3,
      CSR_CENTER_Y      = 3'd4,
      CSR_COUNTS_PER_MM = 3'd5
   } csr_index_type;

   // Register reset values
   localparam logic [15:0] FOCAL_X_RESET       = 16'd9600;
   localparam logic [15:0] CENTER_X_RESET      = 16'd5120;
   localparam logic [15:0] CENTER_Y_RESET      = 16'd3840;
   localparam logic [15:0] COUNTS_PER_MM_RESET = 16'd7808;

   // Micrometres per millimetre times the Q8.8 scale of counts_per_mm
   localparam int UM_SCALE      = 256000;
   localparam int UM_SCALE_BITS = 18;

   // Result fields
   localparam int OUT_BITS = 24;
   localparam int Z_BITS   = 23;
   localparam logic [OUT_BITS-1:0] POS_MAX = 24'h7FFFFF;
   localparam logic [OUT_BITS-1:0] NEG_MAX = 24'h800000;

endpackage

// File: hdl/radial_depth_to_point.sv
// Top level of the radial depth to point pipeline.

// Converts one depth pixel (column, row, raw radial range) into a 3D point in
// micrometres using a pinhole model with the horizontal focal length. The
// block takes one item per clock cycle unless stalled and returns one result
// per item, in order. RTW, the root width of the ray-length square root, is
// 25 at the default 12-bit coordinates. The square root produces one root bit
// per stage and the three coordinate dividers produce one quotient bit per
// stage; these two unrolled units set the depth. All stages advance together:
// while a finished result sits in the output register with rsp_stall high,
// the whole pipeline holds and req_stall is raised; otherwise an item enters
// every cycle. A pixel at the principal point gives x = y = 0, a zero ray
// length gives an all-zero point, counts_per_mm of zero acts as one, and all
// coordinates saturate to their field ranges. With enable or radial_mode low,
// results carry valid_res = 0 and zero coordinates. Write configuration only
// while the pipeline is empty.
module radial_depth_to_point #(
   parameter int COORD_BITS = rdp_pkg::COORD_BITS_DEFAULT,
   parameter int DEPTH_BITS = rdp_pkg::DEPTH_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [COORD_BITS-1:0]               req_column,
   input  logic [COORD_BITS-1:0]               req_row,
   input  logic [DEPTH_BITS-1:0]               req_depth_raw,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rdp_pkg::OUT_BITS-1:0] rsp_point_x,
   output logic signed [rdp_pkg::OUT_BITS-1:0] rsp_point_y,
   output logic [rdp_pkg::Z_BITS-1:0]          rsp_point_z,
   output logic                                rsp_valid_res,
   input  logic                                csr_we,
   input  logic [rdp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rdp_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   // Width plan, all derived from the parameters
   localparam int UW   = COORD_BITS + 4;            // pixel index in Q.4
   localparam int AW   = (UW > 16) ? UW : 16;       // |dx|, |dy|, focal
   localparam int D2W  = 2 * AW + 2;                // dx^2 + dy^2 + f^2
   localparam int SRW  = D2W + 16;                  // radicand d2 << 16
   localparam int RTW  = (SRW + 1) / 2;             // ray length root
   localparam int DENW = 16 + RTW;                  // counts_per_mm * root
   localparam int MW   = DEPTH_BITS + AW;           // raw * |c|
   localparam int PW   = MW + rdp_pkg::UM_SCALE_BITS;
   localparam int NPW  = PW + 8 + 1;                // numerator plus half divisor
   localparam int QB   = rdp_pkg::OUT_BITS;         // quotient bits
   localparam int CW   = (NPW > DENW + QB) ? NPW : DENW + QB;

   typedef struct packed {
      logic [PW-1:0] px;
      logic [PW-1:0] py;
      logic [PW-1:0] pz;
      logic          nx;
      logic          ny;
      logic          ok;
   } sq_carry_type;

   typedef struct packed {
      logic [DENW-1:0] den;
      logic            nx;
      logic            ny;
      logic            ok;
      logic            zero;
   } dv_carry_type;

   // ---------------------------------------------------------------- config
   logic        enable_ff;
   logic        radial_ff;
   logic [15:0] focal_x_ff;
   logic [15:0] center_x_ff;
   logic [15:0] center_y_ff;
   logic [15:0] cpm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         radial_ff   <= 1'b0;
         focal_x_ff  <= rdp_pkg::FOCAL_X_RESET;
         center_x_ff <= rdp_pkg::CENTER_X_RESET;
         center_y_ff <= rdp_pkg::CENTER_Y_RESET;
         cpm_ff      <= rdp_pkg::COUNTS_PER_MM_RESET;
      end else if (csr_we) begin
         unique case (rdp_pkg::csr_index_type'(csr_index))
            rdp_pkg::CSR_ENABLE:        enable_ff   <= csr_wdata[0];
            rdp_pkg::CSR_RADIAL_MODE:   radial_ff   <= csr_wdata[0];
            rdp_pkg::CSR_FOCAL_X:       focal_x_ff  <= csr_wdata;
            rdp_pkg::CSR_CENTER_X:      center_x_ff <= csr_wdata;
            rdp_pkg::CSR_CENTER_Y:      center_y_ff <= csr_wdata;
            rdp_pkg::CSR_COUNTS_PER_MM: cpm_ff      <= csr_wdata;
            default: ;  // drop writes to unknown registers
         endcase
      end
   end

   // ------------------------------------------------------- flow control
   logic out_v_ff;
   logic adv;

   // Advance every stage unless a finished item waits at the output
   assign adv       = !(out_v_ff && rsp_stall);
   assign req_stall = out_v_ff && rsp_stall;

   // ------------------------------------------ stage 1: offsets from center
   logic [AW-1:0] u16_w, v16_w, cx_w, cy_w, ax_w, ay_w;
   logic          nx_w, ny_w;

   always_comb begin
      u16_w = AW'({req_column, 4'b0000});
      v16_w = AW'({req_row, 4'b0000});
      cx_w  = AW'(center_x_ff);
      cy_w  = AW'(center_y_ff);
      nx_w  = u16_w < cx_w;
      ny_w  = v16_w < cy_w;
      ax_w  = nx_w ? cx_w - u16_w : u16_w - cx_w;
      ay_w  = ny_w ? cy_w - v16_w : v16_w - cy_w;
   end

   logic                  v1_ff;
   logic [AW-1:0]         ax1_ff, ay1_ff;
   logic                  nx1_ff, ny1_ff, ok1_ff;
   logic [DEPTH_BITS-1:0] raw1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax1_ff  <= ax_w;
         ay1_ff  <= ay_w;
         nx1_ff  <= nx_w;
         ny1_ff  <= ny_w;
         ok1_ff  <= enable_ff && radial_ff;
         raw1_ff <= req_depth_raw;
      end
   end

   // --------------------------------------- stage 2: squares and raw * |c|
   logic [2*AW-1:0] ax2_w, ay2_w, fx2_w;
   logic [MW-1:0]   rawm_w;

   always_comb begin
      ax2_w  = (2*AW)'(ax1_ff);
      ay2_w  = (2*AW)'(ay1_ff);
      fx2_w  = (2*AW)'(focal_x_ff);
      rawm_w = MW'(raw1_ff);
   end

   logic            v2_ff;
   logic [2*AW-1:0] sqx2_ff, sqy2_ff, sqf2_ff;
   logic [MW-1:0]   mx2_ff, my2_ff, mz2_ff;
   logic            nx2_ff, ny2_ff, ok2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx2_ff <= ax2_w * ax2_w;
         sqy2_ff <= ay2_w * ay2_w;
         sqf2_ff <= fx2_w * fx2_w;
         mx2_ff  <= rawm_w * MW'(ax1_ff);
         my2_ff  <= rawm_w * MW'(ay1_ff);
         mz2_ff  <= rawm_w * MW'(focal_x_ff);
         nx2_ff  <= nx1_ff;
         ny2_ff  <= ny1_ff;
         ok2_ff  <= ok1_ff;
      end
   end

   // ------------------- square-root section: entry stage plus one bit a stage
   logic [D2W-1:0] d2_w;
   sq_carry_type   sq_in_w;

   always_comb begin
      d2_w       = D2W'(sqx2_ff) + D2W'(sqy2_ff) + D2W'(sqf2_ff);
      sq_in_w.px = PW'(mx2_ff) * PW'(rdp_pkg::UM_SCALE);
      sq_in_w.py = PW'(my2_ff) * PW'(rdp_pkg::UM_SCALE);
      sq_in_w.pz = PW'(mz2_ff) * PW'(rdp_pkg::UM_SCALE);
      sq_in_w.nx = nx2_ff;
      sq_in_w.ny = ny2_ff;
      sq_in_w.ok = ok2_ff;
   end

   logic         sq_v_ff [RTW+1];
   logic [SRW-1:0] sq_n_ff [RTW+1];
   logic [SRW-1:0] sq_r_ff [RTW+1];
   sq_carry_type sq_c_ff [RTW+1];
   logic [SRW-1:0] sq_t_w  [RTW];
   logic [SRW-1:0] sq_b_w  [RTW];

   always_comb begin
      for (int j = 0; j < RTW; j++) begin
         sq_b_w[j] = SRW'(1) << (2 * (RTW - 1 - j));
         sq_t_w[j] = sq_r_ff[j] + sq_b_w[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= RTW; j++) begin
            sq_v_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         sq_v_ff[0] <= v2_ff;
         sq_n_ff[0] <= {d2_w, 16'h0000};
         sq_r_ff[0] <= '0;
         sq_c_ff[0] <= sq_in_w;
         for (int j = 0; j < RTW; j++) begin
            sq_v_ff[j+1] <= sq_v_ff[j];
            sq_c_ff[j+1] <= sq_c_ff[j];
            if (sq_n_ff[j] >= sq_t_w[j]) begin
               sq_n_ff[j+1] <= sq_n_ff[j] - sq_t_w[j];
               sq_r_ff[j+1] <= (sq_r_ff[j] >> 1) + sq_b_w[j];
            end else begin
               sq_n_ff[j+1] <= sq_n_ff[j];
               sq_r_ff[j+1] <= sq_r_ff[j] >> 1;
            end
         end
      end
   end

   // ----------------------------------------------- stage D: divisor
   logic [RTW-1:0] root_w;
   logic [15:0]    cpm_w;

   assign root_w = sq_r_ff[RTW][RTW-1:0];
   assign cpm_w  = (cpm_ff == 16'd0) ? 16'd1 : cpm_ff;

   logic            dd_v_ff;
   logic [DENW-1:0] dd_den_ff;
   logic            dd_zero_ff;
   sq_carry_type    dd_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dd_v_ff <= 1'b0;
      end else if (adv) begin
         dd_v_ff <= sq_v_ff[RTW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dd_den_ff  <= DENW'(cpm_w) * DENW'(root_w);
         dd_zero_ff <= root_w == '0;
         dd_c_ff    <= sq_c_ff[RTW];
      end
   end

   // ---------------------------------------- stage E: rounded numerators
   logic           ee_v_ff;
   logic [NPW-1:0] ee_np_ff [3];
   dv_carry_type   ee_c_ff;
   logic [NPW-1:0] half_w;

   assign half_w = NPW'(dd_den_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         ee_v_ff <= 1'b0;
      end else if (adv) begin
         ee_v_ff <= dd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ee_np_ff[0]  <= NPW'({dd_c_ff.px, 8'h00}) + half_w;
         ee_np_ff[1]  <= NPW'({dd_c_ff.py, 8'h00}) + half_w;
         ee_np_ff[2]  <= NPW'({dd_c_ff.pz, 8'h00}) + half_w;
         ee_c_ff.den  <= dd_den_ff;
         ee_c_ff.nx   <= dd_c_ff.nx;
         ee_c_ff.ny   <= dd_c_ff.ny;
         ee_c_ff.ok   <= dd_c_ff.ok;
         ee_c_ff.zero <= dd_zero_ff;
      end
   end

   // -------- divider section: overflow check then one quotient bit a stage
   logic           dv_v_ff   [QB+1];
   dv_carry_type   dv_c_ff   [QB+1];
   logic [NPW-1:0] dv_rem_ff [QB+1][3];
   logic [QB-1:0]  dv_quo_ff [QB+1][3];
   logic           dv_ovf_ff [QB+1][3];
   logic [CW-1:0]  dv_sub_w  [QB];

   always_comb begin
      for (int j = 0; j < QB; j++) begin
         dv_sub_w[j] = CW'(dv_c_ff[j].den) << (QB - 1 - j);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QB; j++) begin
            dv_v_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         dv_v_ff[0] <= ee_v_ff;
         dv_c_ff[0] <= ee_c_ff;
         for (int l = 0; l < 3; l++) begin
            dv_rem_ff[0][l] <= ee_np_ff[l];
            dv_quo_ff[0][l] <= '0;
            // quotient would need more than QB bits: saturate
            dv_ovf_ff[0][l] <= NPW'(ee_c_ff.den) <= (ee_np_ff[l] >> QB);
         end
         for (int j = 0; j < QB; j++) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
            dv_c_ff[j+1] <= dv_c_ff[j];
            for (int l = 0; l < 3; l++) begin
               dv_ovf_ff[j+1][l] <= dv_ovf_ff[j][l];
               if (CW'(dv_rem_ff[j][l]) >= dv_sub_w[j]) begin
                  dv_rem_ff[j+1][l] <= dv_rem_ff[j][l] - dv_sub_w[j][NPW-1:0];
                  dv_quo_ff[j+1][l] <= dv_quo_ff[j][l] | (QB'(1) << (QB - 1 - j));
               end else begin
                  dv_rem_ff[j+1][l] <= dv_rem_ff[j][l];
                  dv_quo_ff[j+1][l] <= dv_quo_ff[j][l];
               end
            end
         end
      end
   end

   // --------------------------------- output stage: sign, saturate, special
   dv_carry_type  fin_c_w;
   logic [QB-1:0] mag_x_w, mag_y_w, mag_z_w;
   logic [QB-1:0] px_in, py_in;
   logic [rdp_pkg::Z_BITS-1:0] pz_in;

   always_comb begin
      fin_c_w = dv_c_ff[QB];
      if (fin_c_w.nx) begin
         mag_x_w = (dv_ovf_ff[QB][0] || dv_quo_ff[QB][0] > rdp_pkg::NEG_MAX)
                   ? rdp_pkg::NEG_MAX : dv_quo_ff[QB][0];
         px_in   = QB'(0) - mag_x_w;
      end else begin
         mag_x_w = (dv_ovf_ff[QB][0] || dv_quo_ff[QB][0] > rdp_pkg::POS_MAX)
                   ? rdp_pkg::POS_MAX : dv_quo_ff[QB][0];
         px_in   = mag_x_w;
      end
      if (fin_c_w.ny) begin
         mag_y_w = (dv_ovf_ff[QB][1] || dv_quo_ff[QB][1] > rdp_pkg::NEG_MAX)
                   ? rdp_pkg::NEG_MAX : dv_quo_ff[QB][1];
         py_in   = QB'(0) - mag_y_w;
      end else begin
         mag_y_w = (dv_ovf_ff[QB][1] || dv_quo_ff[QB][1] > rdp_pkg::POS_MAX)
                   ? rdp_pkg::POS_MAX : dv_quo_ff[QB][1];
         py_in   = mag_y_w;
      end
      mag_z_w = (dv_ovf_ff[QB][2] || dv_quo_ff[QB][2] > rdp_pkg::POS_MAX)
                ? rdp_pkg::POS_MAX : dv_quo_ff[QB][2];
      pz_in   = mag_z_w[rdp_pkg::Z_BITS-1:0];
      // invalid items and a zero ray length give an all-zero point
      if (!fin_c_w.ok || fin_c_w.zero) begin
         px_in = '0;
         py_in = '0;
         pz_in = '0;
      end
   end

   logic [QB-1:0]              out_x_ff, out_y_ff;
   logic [rdp_pkg::Z_BITS-1:0] out_z_ff;
   logic                       out_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_v_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_x_ff  <= px_in;
         out_y_ff  <= py_in;
         out_z_ff  <= pz_in;
         out_ok_ff <= fin_c_w.ok;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_point_x   = out_x_ff;
   assign rsp_point_y   = out_y_ff;
   assign rsp_point_z   = out_z_ff;
   assign rsp_valid_res = out_ok_ff;

endmodule

// File: hdl/rdp_checker.sv
// Port-level checks for the radial depth to point pipeline, bound to the top.
module rdp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [rdp_pkg::OUT_BITS-1:0] rsp_point_x,
   input logic signed [rdp_pkg::OUT_BITS-1:0] rsp_point_y,
   input logic [rdp_pkg::Z_BITS-1:0]          rsp_point_z,
   input logic                                rsp_valid_res
);

   // Input side stalls only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // Pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Invalid results carry a zero point
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |->
         (rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0))
      else $error("invalid result with nonzero point");

   // A stalled result stays valid and keeps its x and z coordinates
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_z)))
      else $error("stalled result changed");

endmodule

bind radial_depth_to_point rdp_checker u_rdp_checker (.*);
